[src/pdta_pkg.sv]
// Shared types and constants for the pair distance threshold accuracy block.
// No dependencies; every other source file imports this package.
`default_nettype none

package pdta_pkg;

  localparam int ELEM_W    = 16;
  localparam int ABS_W     = 16;
  localparam int SQ_W      = 32;
  localparam int DIST_W    = 40;
  localparam int CNT_W     = 13;
  localparam int FRAC_W    = 17;
  localparam int MAX_PAIRS = 4096;

  localparam logic [CNT_W-1:0]  CNT_CAP      = CNT_W'(MAX_PAIRS > 8191 ? 8191 : MAX_PAIRS);
  localparam logic [DIST_W-1:0] DIST_MAX     = {DIST_W{1'b1}};
  localparam logic [DIST_W-1:0] MARGIN_RESET = DIST_W'(65536);

  // Restoring division of correct * 2^16 by the pair count, one quotient bit a cycle.
  localparam int DIV_STEPS = 17;
  localparam int STEP_W    = 5;
  localparam int REM_W     = CNT_W + 1;

  // One finished pair, handed from the front part to the back part.
  typedef struct packed {
    logic              pair_correct;
    logic [DIST_W-1:0] distance_sq;
    logic [CNT_W-1:0]  correct_total;
    logic [CNT_W-1:0]  pair_total;
    logic              batch_done;
  } pair_rec_t;

endpackage

`default_nettype wire

[src/pdta_if.sv]
// Channel interfaces of the pair distance threshold accuracy block.
// Depends on pdta_pkg for field widths.
`default_nettype none

interface pdta_in_if;
  import pdta_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [ELEM_W-1:0] elem_first;
  logic signed [ELEM_W-1:0] elem_second;
  logic                     pair_label;
  logic                     last_element;
  logic                     last_pair;

  modport source (output valid, elem_first, elem_second, pair_label, last_element, last_pair,
                  input ready);
  modport sink (input valid, elem_first, elem_second, pair_label, last_element, last_pair,
                output ready);
endinterface

interface pdta_out_if;
  import pdta_pkg::*;
  logic              valid;
  logic              ready;
  logic              pair_correct;
  logic [DIST_W-1:0] distance_sq;
  logic [CNT_W-1:0]  correct_total;
  logic              batch_done;
  logic [FRAC_W-1:0] accuracy_fraction;

  modport source (output valid, pair_correct, distance_sq, correct_total, batch_done,
                  accuracy_fraction, input ready);
  modport sink (input valid, pair_correct, distance_sq, correct_total, batch_done,
                accuracy_fraction, output ready);
endinterface

`default_nettype wire

[src/pdta_front.sv]
// Front part: difference, square, saturating accumulation, threshold test and counters.
// Depends on pdta_pkg and pdta_if; pushes one pair record per finished pair.
`default_nettype none

module pdta_front
  import pdta_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [DIST_W-1:0] margin_threshold,
  pdta_in_if.sink                elems,
  output pair_rec_t              rec,
  output logic                   rec_valid,
  input  wire logic              rec_ready
);

  logic              s1_valid, s1_label, s1_last_el, s1_last_pr;
  logic [ABS_W-1:0]  s1_abs;
  logic              s2_valid, s2_label, s2_last_el, s2_last_pr;
  logic [SQ_W-1:0]   s2_sq;
  logic [DIST_W-1:0] distance_accum;
  logic [CNT_W-1:0]  pair_count, correct_count;

  logic                   adv, accept;
  logic signed [ELEM_W:0] diff;
  logic [ELEM_W:0]        diff_abs;
  logic [DIST_W:0]        sum;
  logic [DIST_W-1:0]      pair_dist;
  logic                   ok;
  logic [CNT_W-1:0]       pair_count_next, correct_count_next;

  // The pipeline holds whenever a finished pair cannot enter the queue.
  assign rec_valid   = s2_valid && s2_last_el;
  assign adv         = !rec_valid || rec_ready;
  assign elems.ready = adv;
  assign accept      = elems.valid && adv;

  assign diff     = (ELEM_W+1)'(elems.elem_first) - (ELEM_W+1)'(elems.elem_second);
  assign diff_abs = diff[ELEM_W] ? (ELEM_W+1)'(-diff) : (ELEM_W+1)'(diff);

  assign sum       = {1'b0, distance_accum} + {{(DIST_W+1-SQ_W){1'b0}}, s2_sq};
  assign pair_dist = sum[DIST_W] ? DIST_MAX : sum[DIST_W-1:0];
  assign ok        = s2_label ? (pair_dist <= margin_threshold)
                              : (pair_dist > margin_threshold);

  always_comb begin
    pair_count_next    = (pair_count < CNT_CAP) ? pair_count + 1'b1 : pair_count;
    correct_count_next = (ok && (correct_count < pair_count_next)) ? correct_count + 1'b1
                                                                   : correct_count;
  end

  assign rec.pair_correct  = ok;
  assign rec.distance_sq   = pair_dist;
  assign rec.correct_total = correct_count_next;
  assign rec.pair_total    = pair_count_next;
  assign rec.batch_done    = s2_last_pr;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_abs     <= diff_abs[ABS_W-1:0];
      s1_label   <= elems.pair_label;
      s1_last_el <= elems.last_element;
      s1_last_pr <= elems.last_pair;
      s2_sq      <= SQ_W'(s1_abs * s1_abs);
      s2_label   <= s1_label;
      s2_last_el <= s1_last_el;
      s2_last_pr <= s1_last_pr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid       <= 1'b0;
      s2_valid       <= 1'b0;
      distance_accum <= '0;
      pair_count     <= '0;
      correct_count  <= '0;
    end else if (adv) begin
      s1_valid <= accept;
      s2_valid <= s1_valid;
      if (s2_valid) begin
        if (s2_last_el) begin
          distance_accum <= '0;
          if (s2_last_pr) begin
            pair_count    <= '0;
            correct_count <= '0;
          end else begin
            pair_count    <= pair_count_next;
            correct_count <= correct_count_next;
          end
        end else begin
          distance_accum <= pair_dist;
        end
      end
    end
  end

  a_correct_le_pairs: assert property (@(posedge clk) disable iff (rst)
    correct_count <= pair_count)
    else $error("correct count exceeds pair count");

  a_pairs_capped: assert property (@(posedge clk) disable iff (rst)
    pair_count <= CNT_CAP)
    else $error("pair count beyond its cap");

  a_stall_holds_accum: assert property (@(posedge clk) disable iff (rst)
    rec_valid && !rec_ready |=> $stable(distance_accum) && $stable(pair_count))
    else $error("accumulator moved while the queue was full");

endmodule

`default_nettype wire

[src/pdta_queue.sv]
// Short FIFO of pair records between the front and back parts.
// Depends on pdta_pkg for the record type.
`default_nettype none

module pdta_queue
  import pdta_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  wire logic clk,
  input  wire logic rst,
  input  pair_rec_t wr_rec,
  input  wire logic wr_valid,
  output logic      wr_ready,
  output pair_rec_t rd_rec,
  output logic      rd_valid,
  input  wire logic rd_ready
);

  localparam int PTR_W  = $clog2(DEPTH);
  localparam int FILL_W = $clog2(DEPTH + 1);

  pair_rec_t          entries [DEPTH];
  logic [PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [FILL_W-1:0]  fill;
  logic               push, pop;

  assign wr_ready = (fill != FILL_W'(DEPTH));
  assign rd_valid = (fill != '0);
  assign rd_rec   = entries[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

[src/pdta_back.sv]
// Back part: passes pair results to the output register and, at the end of a batch,
// runs a bit-serial divider for the accuracy. Depends on pdta_pkg and pdta_if.
`default_nettype none

module pdta_back
  import pdta_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  pair_rec_t rec,
  input  wire logic rec_valid,
  output logic      rec_ready,
  pdta_out_if.source res
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0]        state;
  logic [STEP_W-1:0] step;
  logic [REM_W-1:0]  rem;
  logic [FRAC_W-1:0] quot;
  pair_rec_t         work;

  logic              out_valid;
  logic              out_free;
  logic              take_plain;
  logic [REM_W-1:0]  divisor;
  logic              bit_set;
  logic [REM_W-1:0]  rem_sub;

  assign out_free   = !out_valid || res.ready;
  assign take_plain = (state == ST_IDLE) && rec_valid && !rec.batch_done && out_free;
  assign rec_ready  = (state == ST_IDLE) && (rec.batch_done || out_free);

  assign divisor = {1'b0, work.pair_total};
  assign bit_set = (rem >= divisor);
  assign rem_sub = bit_set ? rem - divisor : rem;

  assign res.valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      step      <= '0;
    end else begin
      // A new beat takes the output register when it is free; otherwise a taken beat
      // leaves it empty.
      if (take_plain || ((state == ST_FIN) && out_free)) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (rec_valid && rec.batch_done) begin
            step  <= '0;
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          step <= step + 1'b1;
          if (step == STEP_W'(DIV_STEPS - 1)) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (take_plain) begin
          res.pair_correct      <= rec.pair_correct;
          res.distance_sq       <= rec.distance_sq;
          res.correct_total     <= rec.correct_total;
          res.batch_done        <= 1'b0;
          res.accuracy_fraction <= '0;
        end else if (rec_valid && rec.batch_done) begin
          work <= rec;
          rem  <= {1'b0, rec.correct_total};
          quot <= '0;
        end
      end
      ST_DIV: begin
        quot <= {quot[FRAC_W-2:0], bit_set};
        rem  <= {rem_sub[REM_W-2:0], 1'b0};
      end
      ST_FIN: begin
        if (out_free) begin
          res.pair_correct      <= work.pair_correct;
          res.distance_sq       <= work.distance_sq;
          res.correct_total     <= work.correct_total;
          res.batch_done        <= 1'b1;
          res.accuracy_fraction <= quot;
        end
      end
      default: begin
      end
    endcase
  end

  a_div_step_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> step < STEP_W'(DIV_STEPS))
    else $error("divider ran past its last step");

  a_quot_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_FIN |-> quot <= FRAC_W'(65536))
    else $error("accuracy above one");

  a_divisor_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> work.pair_total != '0)
    else $error("division by a zero pair count");

endmodule

`default_nettype wire

[src/pair_distance_threshold_accuracy.sv]
// Top level of the pair distance threshold accuracy block.
// Depends on pdta_pkg, pdta_if, pdta_front, pdta_queue and pdta_back.
//
// Usage. Element beats arrive on the elems channel (valid/ready), one element of
// each embedding per beat, with last_element on the final element of a pair and
// last_pair alongside it on the final pair of a batch. For every beat carrying
// last_element one result beat leaves on the results channel: the saturated Q24.16
// squared distance, whether the pair was classified correctly against the margin,
// and the running count of correct pairs. The closing result of a batch also
// carries the Q1.16 accuracy, and the pair counters restart for the next batch.
// The user must write the margin through cfg_write_en/cfg_write_data only while the
// block is idle; the block itself does not enforce this. The margin resets to 1.0.
// Throughput is one element beat per cycle while the pair queue has room. A pair's
// result passes through the s1 and s2 pipeline registers, the pair queue and the
// output register. A batch's closing result also passes through the bit-serial
// divider; the pair queue in front of the divider lets element beats keep flowing
// meanwhile, and it fills when pairs keep finishing while the divider runs.
// When the receiver stalls, the output register holds its beat, the queue fills and
// the elems channel then drops ready. Reset (synchronous, active high) clears the
// accumulator, both counters, the queue and the output register.
`default_nettype none

module pair_distance_threshold_accuracy
  import pdta_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_write_en,
  input  wire logic [DIST_W-1:0] cfg_write_data,
  pdta_in_if.sink                elems,
  pdta_out_if.source             results
);

  logic [DIST_W-1:0] margin_threshold;

  pair_rec_t front_rec, back_rec;
  logic      front_valid, front_ready;
  logic      back_valid, back_ready;

  // The single configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      margin_threshold <= MARGIN_RESET;
    end else if (cfg_write_en) begin
      margin_threshold <= cfg_write_data;
    end
  end

  pdta_front u_front (
    .clk              (clk),
    .rst              (rst),
    .margin_threshold (margin_threshold),
    .elems            (elems),
    .rec              (front_rec),
    .rec_valid        (front_valid),
    .rec_ready        (front_ready)
  );

  pdta_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_rec   (front_rec),
    .wr_valid (front_valid),
    .wr_ready (front_ready),
    .rd_rec   (back_rec),
    .rd_valid (back_valid),
    .rd_ready (back_ready)
  );

  pdta_back u_back (
    .clk       (clk),
    .rst       (rst),
    .rec       (back_rec),
    .rec_valid (back_valid),
    .rec_ready (back_ready),
    .res       (results)
  );

endmodule

`default_nettype wire
